// ----- rtl/rdg_pkg.sv -----
`timescale 1ns / 1ps

package rdg_pkg;

	localparam int DEST_WIDTH  = 64;
	localparam int DEST_HEIGHT = 64;

	localparam int COORD_W  = 6;
	localparam int DCOUNT_W = 7;
	localparam int SRC_W    = 10;
	localparam int STEP_W   = 14;
	localparam int TINT_W   = 11;
	localparam int FRAC_W   = 10;
	localparam int CFG_W    = 14;
	localparam int IDX_W    = 2;

	localparam int MILLI      = 1000;
	localparam int RECIP_1000 = 16778;
	localparam int RECIP_SH   = 24;

	localparam int LUMA_R     = 30;
	localparam int LUMA_G     = 59;
	localparam int LUMA_B     = 11;
	localparam int SUM_W      = 15;
	localparam int RECIP_100  = 5243;
	localparam int LUMA_SH    = 19;
	localparam int LUMA_PROD_W = 28;

	localparam int QPTR_W      = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_W;

	typedef enum logic [IDX_W-1:0] {
		REG_SOURCE_WIDTH = 2'd0,
		REG_COLUMN_STEP  = 2'd1,
		REG_ROW_STEP     = 2'd2
	} reg_idx_t;

	// step split into whole pixels and thousandths
	typedef struct packed {
		logic [4:0]        whole;
		logic [FRAC_W-1:0] frac;
	} step_t;

	typedef struct packed {
		logic [15:0]        pixel;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic               frame_last;
	} item_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	function automatic step_t split_step(input logic [STEP_W-1:0] s);
		logic [28:0] prod;
		logic [4:0]  q;
		logic [14:0] qk;
		step_t       r;
		prod = 29'(s) * 29'(RECIP_1000);
		q = prod[28:RECIP_SH];
		qk = 15'(q) * 15'(MILLI);
		r.whole = q;
		r.frac = FRAC_W'(15'(s) - qk);
		return r;
	endfunction

endpackage

// ----- rtl/rdg_if.sv -----
`timescale 1ns / 1ps

interface rdg_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;
	logic        frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface rdg_gray_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  gray;
	logic [rdg_pkg::COORD_W-1:0] dest_x;
	logic [rdg_pkg::COORD_W-1:0] dest_y;
	logic                        frame_last;

	modport source (output valid, output gray, output dest_x, output dest_y,
		output frame_last, input ready);
	modport sink (input valid, input gray, input dest_x, input dest_y,
		input frame_last, output ready);
endinterface

// ----- rtl/rdg_front.sv -----
`timescale 1ns / 1ps

module rdg_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [rdg_pkg::IDX_W-1:0]  wr_index,
	input  logic [rdg_pkg::CFG_W-1:0]  wr_data,
	rdg_pix_if.sink                    pixels,
	input  rdg_pkg::q_stat_t           q_stat,
	output logic                       push,
	output rdg_pkg::item_t             item
);

	logic [rdg_pkg::SRC_W-1:0]    src_width_q;
	rdg_pkg::step_t               col_step_q;
	rdg_pkg::step_t               row_step_q;

	logic [rdg_pkg::SRC_W-1:0]    src_col_q, src_row_q;
	logic [rdg_pkg::DCOUNT_W-1:0] dst_col_q, dst_row_q;
	logic [rdg_pkg::TINT_W-1:0]   col_int_q, row_int_q;
	logic [rdg_pkg::FRAC_W-1:0]   col_frac_q, row_frac_q;

	logic [rdg_pkg::SRC_W-1:0]    sc, sr;
	logic [rdg_pkg::DCOUNT_W-1:0] dc, dr;
	logic [rdg_pkg::TINT_W-1:0]   ci, ri;
	logic [rdg_pkg::FRAC_W-1:0]   cf, rf;

	logic                         acc, row_hit, col_hit, hit, row_end, last_col;
	logic [rdg_pkg::TINT_W-1:0]   col_fsum, row_fsum;
	logic                         col_carry, row_carry;
	logic [rdg_pkg::TINT_W-1:0]   col_nint, row_nint;
	logic [rdg_pkg::FRAC_W-1:0]   col_nfrac, row_nfrac;

	assign pixels.ready = !q_stat.full;
	assign acc = pixels.valid && pixels.ready;

	// frame start restarts every counter before the word is handled
	always_comb begin
		if (pixels.frame_start) begin
			sc = '0; sr = '0; dc = '0; dr = '0;
			ci = '0; ri = '0; cf = '0; rf = '0;
		end else begin
			sc = src_col_q; sr = src_row_q; dc = dst_col_q; dr = dst_row_q;
			ci = col_int_q; ri = row_int_q; cf = col_frac_q; rf = row_frac_q;
		end
	end

	always_comb begin
		col_fsum  = rdg_pkg::TINT_W'(cf) + rdg_pkg::TINT_W'(col_step_q.frac);
		col_carry = col_fsum >= rdg_pkg::TINT_W'(rdg_pkg::MILLI);
		col_nfrac = col_carry ? rdg_pkg::FRAC_W'(col_fsum - rdg_pkg::TINT_W'(rdg_pkg::MILLI))
			: rdg_pkg::FRAC_W'(col_fsum);
		col_nint  = ci + rdg_pkg::TINT_W'(col_step_q.whole) + rdg_pkg::TINT_W'(col_carry);

		row_fsum  = rdg_pkg::TINT_W'(rf) + rdg_pkg::TINT_W'(row_step_q.frac);
		row_carry = row_fsum >= rdg_pkg::TINT_W'(rdg_pkg::MILLI);
		row_nfrac = row_carry ? rdg_pkg::FRAC_W'(row_fsum - rdg_pkg::TINT_W'(rdg_pkg::MILLI))
			: rdg_pkg::FRAC_W'(row_fsum);
		row_nint  = ri + rdg_pkg::TINT_W'(row_step_q.whole) + rdg_pkg::TINT_W'(row_carry);

		row_hit = (dr < rdg_pkg::DCOUNT_W'(rdg_pkg::DEST_HEIGHT))
			&& (ri == rdg_pkg::TINT_W'(sr));
		col_hit = (dc < rdg_pkg::DCOUNT_W'(rdg_pkg::DEST_WIDTH))
			&& (ci == rdg_pkg::TINT_W'(sc)) && (sc < src_width_q);
		hit = row_hit && col_hit;
		last_col = (dc == rdg_pkg::DCOUNT_W'(rdg_pkg::DEST_WIDTH - 1))
			|| (col_nint >= rdg_pkg::TINT_W'(src_width_q));
		row_end = (rdg_pkg::TINT_W'(sc) + rdg_pkg::TINT_W'(1))
			>= rdg_pkg::TINT_W'(src_width_q);
	end

	assign push = acc && hit;

	always_comb begin
		item.pixel      = pixels.pixel;
		item.dest_x     = rdg_pkg::COORD_W'(dc);
		item.dest_y     = rdg_pkg::COORD_W'(dr);
		item.frame_last = (dr == rdg_pkg::DCOUNT_W'(rdg_pkg::DEST_HEIGHT - 1)) && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= rdg_pkg::SRC_W'(160);
			col_step_q  <= rdg_pkg::split_step(rdg_pkg::STEP_W'(2500));
			row_step_q  <= rdg_pkg::split_step(rdg_pkg::STEP_W'(1875));
		end else if (wr_en) begin
			case (rdg_pkg::reg_idx_t'(wr_index))
				rdg_pkg::REG_SOURCE_WIDTH: src_width_q <= wr_data[rdg_pkg::SRC_W-1:0];
				rdg_pkg::REG_COLUMN_STEP: col_step_q <= rdg_pkg::split_step(wr_data);
				rdg_pkg::REG_ROW_STEP: row_step_q <= rdg_pkg::split_step(wr_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0; src_row_q <= '0; dst_col_q <= '0; dst_row_q <= '0;
			col_int_q <= '0; row_int_q <= '0; col_frac_q <= '0; row_frac_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				src_col_q <= '0;
				src_row_q <= (sr != '1) ? sr + rdg_pkg::SRC_W'(1) : sr;
				dst_col_q <= '0;
				col_int_q <= '0;
				col_frac_q <= '0;
				if (row_hit) begin
					dst_row_q <= dr + rdg_pkg::DCOUNT_W'(1);
					row_int_q <= row_nint;
					row_frac_q <= row_nfrac;
				end else begin
					dst_row_q <= dr;
					row_int_q <= ri;
					row_frac_q <= rf;
				end
			end else begin
				src_col_q <= sc + rdg_pkg::SRC_W'(1);
				src_row_q <= sr;
				dst_row_q <= dr;
				row_int_q <= ri;
				row_frac_q <= rf;
				if (hit) begin
					dst_col_q <= dc + rdg_pkg::DCOUNT_W'(1);
					col_int_q <= col_nint;
					col_frac_q <= col_nfrac;
				end else begin
					dst_col_q <= dc;
					col_int_q <= ci;
					col_frac_q <= cf;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_last_on_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		push && item.frame_last |-> item.dest_y == rdg_pkg::COORD_W'(rdg_pkg::DEST_HEIGHT - 1))
		else $error("frame_last outside the last destination row");
`endif

endmodule

// ----- rtl/rdg_queue.sv -----
`timescale 1ns / 1ps

module rdg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rdg_pkg::item_t    push_item,
	input  logic              pop,
	output rdg_pkg::item_t    head,
	output rdg_pkg::q_stat_t  stat
);

	rdg_pkg::item_t              mem_q [rdg_pkg::QUEUE_DEPTH];
	logic [rdg_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [rdg_pkg::QPTR_W:0]    count_q;
	logic                        do_pop;

	assign stat.full  = count_q == (rdg_pkg::QPTR_W+1)'(rdg_pkg::QUEUE_DEPTH);
	assign stat.valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];
	assign do_pop = pop && stat.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rdg_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + rdg_pkg::QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + (rdg_pkg::QPTR_W+1)'(1);
				2'b01: count_q <= count_q - (rdg_pkg::QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push)
		else $error("word written into a full queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (rdg_pkg::QPTR_W+1)'(rdg_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");
`endif

endmodule

// ----- rtl/rdg_back.sv -----
`timescale 1ns / 1ps

module rdg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rdg_pkg::item_t    head,
	input  rdg_pkg::q_stat_t  q_stat,
	output logic              pop,
	rdg_gray_if.source        grays
);

	logic                         valid_s1, valid_s2;
	logic [rdg_pkg::SUM_W-1:0]    sum_s1;
	logic [rdg_pkg::COORD_W-1:0]  dx_s1, dy_s1;
	logic                         last_s1;
	logic [7:0]                   gray_s2;
	logic [rdg_pkg::COORD_W-1:0]  dx_s2, dy_s2;
	logic                         last_s2;

	logic                         adv_s2, load_s1;
	logic [7:0]                   r8, g8, b8;
	logic [rdg_pkg::SUM_W-1:0]    sum;
	logic [rdg_pkg::LUMA_PROD_W-1:0] quo;

	assign adv_s2  = !valid_s2 || grays.ready;
	assign load_s1 = !valid_s1 || adv_s2;
	assign pop     = q_stat.valid && load_s1;

	always_comb begin
		r8 = {head.pixel[15:11], 3'b000};
		g8 = {head.pixel[10:5], 2'b00};
		b8 = {head.pixel[4:0], 3'b000};
		sum = rdg_pkg::SUM_W'(r8) * rdg_pkg::SUM_W'(rdg_pkg::LUMA_R)
			+ rdg_pkg::SUM_W'(g8) * rdg_pkg::SUM_W'(rdg_pkg::LUMA_G)
			+ rdg_pkg::SUM_W'(b8) * rdg_pkg::SUM_W'(rdg_pkg::LUMA_B);
		// divide by 100 through the reciprocal, exact over the sum's range
		quo = rdg_pkg::LUMA_PROD_W'(sum_s1) * rdg_pkg::LUMA_PROD_W'(rdg_pkg::RECIP_100);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= q_stat.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_s1  <= sum;
			dx_s1   <= head.dest_x;
			dy_s1   <= head.dest_y;
			last_s1 <= head.frame_last;
		end
		if (adv_s2 && valid_s1) begin
			gray_s2 <= quo[rdg_pkg::LUMA_SH +: 8];
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			last_s2 <= last_s1;
		end
	end

	assign grays.valid      = valid_s2;
	assign grays.gray       = gray_s2;
	assign grays.dest_x     = dx_s2;
	assign grays.dest_y     = dy_s2;
	assign grays.frame_last = last_s2;

`ifndef SYNTHESIS
	a_gray_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> gray_s2 <= 8'd250)
		else $error("luma above its largest value");
`endif

endmodule

// ----- rtl/rgb565_downscale_to_gray.sv -----
`timescale 1ns / 1ps
// channel   role     handshake      words carried
// pixels    in       valid/ready    pixel[15:0], frame_start
// grays     out      valid/ready    gray[7:0], dest_x[5:0], dest_y[5:0], frame_last
// wr_*      config   wr_en only     wr_index[1:0], wr_data[13:0]
//
// One source word a cycle is taken while the four-entry queue has room.
// A selected word goes through the queue, then the luma-sum register and the
// reciprocal-multiply output register; the output register holds it until grays.ready.
// Reset clears the counters and loads width 160, steps 2500 and 1875.
// A stall on grays fills the queue, and pixels.ready drops only when it is full.

module rgb565_downscale_to_gray (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [rdg_pkg::IDX_W-1:0] wr_index,
	input  logic [rdg_pkg::CFG_W-1:0] wr_data,
	rdg_pix_if.sink                   pixels,
	rdg_gray_if.source                grays
);

	rdg_pkg::q_stat_t q_stat;
	rdg_pkg::item_t   push_item, head;
	logic             push, pop;

	rdg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pixels   (pixels),
		.q_stat   (q_stat),
		.push     (push),
		.item     (push_item)
	);

	rdg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	rdg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.grays  (grays)
	);

endmodule

// ----- sim/rdg_gray_checker.sv -----
`timescale 1ns / 1ps

module rdg_gray_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [rdg_pkg::IDX_W-1:0] wr_index,
	input  logic [rdg_pkg::CFG_W-1:0] wr_data,
	rdg_pix_if                        pixels,
	rdg_gray_if                       grays,
	output int                        fail_count,
	output int                        words_due
);
	import rdg_pkg::*;

	localparam int WIDTH_AT_RESET    = 160;
	localparam int COL_STEP_AT_RESET = 2500;
	localparam int ROW_STEP_AT_RESET = 1875;
	localparam int LUMA_DIV          = 100;
	localparam int SRC_ROW_MAX       = 1023;

	typedef struct packed {
		logic [7:0]         gray;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic               frame_last;
	} gray_word_t;

	gray_word_t gray_words_due[$];

	logic [SRC_W-1:0]    cfg_width;
	logic [STEP_W-1:0]   cfg_col_step;
	logic [STEP_W-1:0]   cfg_row_step;
	logic [SRC_W-1:0]    src_col;
	logic [SRC_W-1:0]    src_row;
	logic [DCOUNT_W-1:0] dst_col;
	logic [DCOUNT_W-1:0] dst_row;
	logic [19:0]         col_target;
	logic [19:0]         row_target;

	function automatic logic [7:0] luma_of(input logic [15:0] px);
		int unsigned weighted;
		weighted = 32'(px[15:11]) * 8 * LUMA_R + 32'(px[10:5]) * 4 * LUMA_G
			+ 32'(px[4:0]) * 8 * LUMA_B;
		return 8'(weighted / LUMA_DIV);
	endfunction

	task automatic restart_frame();
		src_col = '0;
		src_row = '0;
		dst_col = '0;
		dst_row = '0;
		col_target = '0;
		row_target = '0;
	endtask

	// Advance the raster position by one source word and queue the gray word it selects.
	task automatic downscale_pixel(input logic [15:0] px, input logic fs);
		int unsigned next_target;
		logic        row_hit;
		logic        col_hit;
		logic        last_col;
		gray_word_t  w;
		if (fs)
			restart_frame();
		row_hit = dst_row < DEST_HEIGHT && row_target / MILLI == src_row;
		col_hit = dst_col < DEST_WIDTH && col_target / MILLI == src_col
			&& src_col < cfg_width;
		if (row_hit && col_hit) begin
			next_target = 32'(col_target) + 32'(cfg_col_step);
			last_col = dst_col == DEST_WIDTH - 1 || next_target / MILLI >= cfg_width;
			w.gray = luma_of(px);
			w.dest_x = dst_col[COORD_W-1:0];
			w.dest_y = dst_row[COORD_W-1:0];
			w.frame_last = dst_row == DEST_HEIGHT - 1 && last_col;
			gray_words_due.push_back(w);
			dst_col = dst_col + 1'b1;
			col_target = next_target[19:0];
		end
		if (int'(src_col) + 1 >= int'(cfg_width)) begin
			src_col = '0;
			// saturate rather than wrap
			if (src_row != SRC_ROW_MAX)
				src_row = src_row + 1'b1;
			if (row_hit) begin
				dst_row = dst_row + 1'b1;
				row_target = row_target + 20'(cfg_row_step);
			end
			dst_col = '0;
			col_target = '0;
		end else begin
			src_col = src_col + 1'b1;
		end
	endtask

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gray_word_t exp_w;
		if (!arst_n) begin
			cfg_width = WIDTH_AT_RESET;
			cfg_col_step = COL_STEP_AT_RESET;
			cfg_row_step = ROW_STEP_AT_RESET;
			restart_frame();
			gray_words_due.delete();
			words_due = 0;
		end else begin
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_SOURCE_WIDTH: cfg_width = wr_data[SRC_W-1:0];
					REG_COLUMN_STEP:  cfg_col_step = wr_data[STEP_W-1:0];
					REG_ROW_STEP:     cfg_row_step = wr_data[STEP_W-1:0];
					default: ;
				endcase
			end
			// retire the output word before queueing the new one
			if (grays.valid && grays.ready) begin
				if (gray_words_due.size() == 0) begin
					fail_count++;
					$display("%0t: expected no word, got gray %0d x %0d y %0d last %0d",
						$time, grays.gray, grays.dest_x, grays.dest_y, grays.frame_last);
				end else begin
					exp_w = gray_words_due.pop_front();
					check_field("gray", exp_w.gray, grays.gray);
					check_field("dest_x", exp_w.dest_x, grays.dest_x);
					check_field("dest_y", exp_w.dest_y, grays.dest_y);
					check_field("frame_last", exp_w.frame_last, grays.frame_last);
				end
			end
			if (pixels.valid && pixels.ready)
				downscale_pixel(pixels.pixel, pixels.frame_start);
			words_due = gray_words_due.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import rdg_pkg::*;

	localparam int RUN_LIMIT    = 1000000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [15:0] CORNER_PX [8] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
		16'h001F, 16'h0821, 16'hFFDF, 16'h8410};

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;
	int               fail_count;
	int               words_due;
	int               hold_off_req;
	int               cycle_count;
	bit               src_idle_en;

	rdg_pix_if  pixels();
	rdg_gray_if grays();

	rgb565_downscale_to_gray i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pixels   (pixels),
		.grays    (grays)
	);

	rdg_gray_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.pixels     (pixels),
		.grays      (grays),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : gray_sink
		int  stall;
		int  hold_left;
		bit  snk_idle_en;
		grays.ready = 1'b0;
		snk_idle_en = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_off_req > 0) begin
				hold_left = hold_off_req;
				hold_off_req = 0;
				@(negedge clk);
				grays.ready = 1'b0;
				while (hold_left > 0) begin
					@(negedge clk);
					hold_left--;
				end
			end
			if ($urandom_range(0, 39) == 0)
				snk_idle_en = !snk_idle_en;
			stall = snk_idle_en ? $urandom_range(0, 17) : 0;
			repeat (stall) begin
				@(negedge clk);
				grays.ready = 1'b0;
			end
			@(negedge clk);
			grays.ready = 1'b1;
			do @(posedge clk); while (!grays.valid);
		end
	end

	task automatic send_pixel(input logic [15:0] px, input logic fs);
		int gap;
		if ($urandom_range(0, 49) == 0)
			src_idle_en = !src_idle_en;
		gap = src_idle_en ? $urandom_range(0, 17) : 0;
		repeat (gap) begin
			@(negedge clk);
			pixels.valid = 1'b0;
		end
		@(negedge clk);
		pixels.valid = 1'b1;
		pixels.pixel = px;
		pixels.frame_start = fs;
		do @(posedge clk); while (!pixels.ready);
	endtask

	// Drop valid, let every queued word out, then give words with no result time to clear.
	task automatic wait_idle();
		@(negedge clk);
		pixels.valid = 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input int w, input int cs, input int rs);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = REG_SOURCE_WIDTH;
		wr_data = CFG_W'(w);
		@(negedge clk);
		wr_index = REG_COLUMN_STEP;
		wr_data = CFG_W'(cs);
		@(negedge clk);
		wr_index = REG_ROW_STEP;
		wr_data = CFG_W'(rs);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Raster frames open with a start mark; noisy streams scatter marks at random.
	task automatic stream_pixels(input int count, input bit noisy, input bit corners_only);
		logic        fs;
		logic [15:0] px;
		for (int i = 0; i < count; i++) begin
			if (noisy)
				fs = $urandom_range(0, 19) == 0;
			else
				fs = i == 0 || $urandom_range(0, 299) == 0;
			if (corners_only)
				px = CORNER_PX[i % 8];
			else if ($urandom_range(0, 5) == 0)
				px = CORNER_PX[$urandom_range(0, 7)];
			else
				px = 16'($urandom);
			send_pixel(px, fs);
		end
	endtask

	task automatic run_phase(input int w, input int cs, input int rs, input int count,
		input bit noisy);
		wait_idle();
		configure(w, cs, rs);
		src_idle_en = $urandom_range(0, 1);
		stream_pixels(count, noisy, 1'b0);
	endtask

	function automatic int draw_step();
		case ($urandom_range(0, 4))
			0: return 1000;
			1: return 16000;
			default: return $urandom_range(1000, 16000);
		endcase
	endfunction

	initial begin : stimulus
		int w;
		int cs;
		int rs;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_SOURCE_WIDTH;
		wr_data = '0;
		pixels.valid = 1'b0;
		pixels.pixel = '0;
		pixels.frame_start = 1'b0;
		hold_off_req = 0;
		src_idle_en = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// values loaded by reset
		stream_pixels(12, 1'b0, 1'b1);
		// one source column per destination column: every corner colour comes out
		wait_idle();
		configure(64, 1000, 1000);
		stream_pixels(20, 1'b0, 1'b1);
		// width of one: every word ends a row, frame completes then goes quiet
		run_phase(1, 1000, 1000, 70, 1'b0);
		stream_pixels(3, 1'b0, 1'b1);
		// width of zero: nothing is ever selected
		run_phase(0, 1000, 1000, 6, 1'b0);
		// steps under one pixel stall selection until the row or frame restarts
		run_phase(64, 400, 600, 80, 1'b0);

		// long receiver stall so the input backs up
		wait_idle();
		configure(64, 1000, 1000);
		src_idle_en = 1'b0;
		hold_off_req = HOLD_CYCLES;
		stream_pixels(120, 1'b0, 1'b0);

		run_phase(1023, 16000, 16000, 40, 1'b0);
		run_phase(64, 16000, 16000, 50, 1'b0);

		for (int p = 0; p < 3; p++) begin
			w = $urandom_range(0, 4) == 0 ? 64 : $urandom_range(64, 160);
			cs = draw_step();
			rs = draw_step();
			run_phase(w, cs, rs, $urandom_range(w / 4, w / 2), $urandom_range(0, 3) == 0);
		end

		wait_idle();
		if (fail_count == 0 && words_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rdg_pkg.sv
rtl/rdg_if.sv
rtl/rdg_front.sv
rtl/rdg_queue.sv
rtl/rdg_back.sv
rtl/rgb565_downscale_to_gray.sv
sim/rdg_gray_checker.sv
sim/testbench.sv
